// File: rtl/bpfm_pkg.sv
// ----------------------------------------------------------------------------
// Buffer pool frame manager package
// Shared widths, codes and the command and status records that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfm_pkg;

	// Field widths fixed by the word formats.
	localparam int NUM_FRAMES_DEF = 32;
	localparam int MODE_W  = 3;
	localparam int FILE_W  = 8;
	localparam int PAGE_W  = 31;
	localparam int FRAME_W = 6;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 3;
	localparam int PIN_W   = 16;

	// Operation modes.
	localparam logic [MODE_W-1:0] MODE_READ    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_UNPIN   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DISPOSE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FLUSH   = 3'd4;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_FINAL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WBACK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FETCH = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DISP  = 2'd3;

	// Final status codes.
	localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
	localparam logic [STAT_W-1:0] ST_NO_FREE    = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_RES    = 3'd2;
	localparam logic [STAT_W-1:0] ST_BAD_BUF    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_PINNED = 3'd4;
	localparam logic [STAT_W-1:0] ST_PINNED     = 3'd5;
	localparam logic [STAT_W-1:0] ST_RESIDENT   = 3'd6;
	localparam logic [STAT_W-1:0] ST_BAD_FILE   = 3'd7;

	// Datapath operations, one per cycle.
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
	localparam logic [OP_W-1:0] OP_LATCH      = 4'd1;
	localparam logic [OP_W-1:0] OP_MATCH      = 4'd2;
	localparam logic [OP_W-1:0] OP_ENC        = 4'd3;
	localparam logic [OP_W-1:0] OP_VICT       = 4'd4;
	localparam logic [OP_W-1:0] OP_REMOVE     = 4'd5;
	localparam logic [OP_W-1:0] OP_PUT_KEEP   = 4'd6;
	localparam logic [OP_W-1:0] OP_PUT_VICTIM = 4'd7;
	localparam logic [OP_W-1:0] OP_PIN_INC    = 4'd8;
	localparam logic [OP_W-1:0] OP_UNPIN      = 4'd9;
	localparam logic [OP_W-1:0] OP_INSTALL    = 4'd10;
	localparam logic [OP_W-1:0] OP_CLEAR      = 4'd11;
	localparam logic [OP_W-1:0] OP_SCAN_INIT  = 4'd12;
	localparam logic [OP_W-1:0] OP_NEXT       = 4'd13;
	localparam logic [OP_W-1:0] OP_CLEAR_NEXT = 4'd14;

	// Command from the controller.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic              emit;
		logic [KIND_W-1:0] kind;
		logic [STAT_W-1:0] status;
		logic              use_frame;
		logic              req_tag;
		logic              last;
	} cmd_t;

	// Status back to the controller.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              file_zero;
		logic              love;
		logic              hit;
		logic              pin_zero;
		logic              victim_none;
		logic              victim_dirty;
		logic              scan_end;
		logic              cand;
		logic              out_free;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/bpfm_if.sv
// ----------------------------------------------------------------------------
// Buffer pool frame manager channels
// Request and response interfaces with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpfm_in_if import bpfm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [FILE_W-1:0] file_id;
	logic [PAGE_W-1:0] page_no;
	logic              dirty_mark;
	logic              love;

	modport source (output valid, mode, file_id, page_no, dirty_mark, love, input ready);
	modport sink   (input valid, mode, file_id, page_no, dirty_mark, love, output ready);
endinterface

interface bpfm_out_if import bpfm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [STAT_W-1:0]  status;
	logic [FRAME_W-1:0] frame;
	logic [FILE_W-1:0]  req_file;
	logic [PAGE_W-1:0]  req_page;
	logic               last;

	modport source (output valid, kind, status, frame, req_file, req_page, last, input ready);
	modport sink   (input valid, kind, status, frame, req_file, req_page, last, output ready);
endinterface

`default_nettype wire

// File: rtl/bpfm_ctrl.sv
// ----------------------------------------------------------------------------
// Buffer pool frame manager controller
// Sequences each request through tag match, list updates and result words.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfm_ctrl import bpfm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t st,
	output cmd_t       cmd
);

	localparam int S_W = 4;
	localparam logic [S_W-1:0] S_IDLE  = 4'd0;
	localparam logic [S_W-1:0] S_MATCH = 4'd1;
	localparam logic [S_W-1:0] S_ENC   = 4'd2;
	localparam logic [S_W-1:0] S_DEC   = 4'd3;
	localparam logic [S_W-1:0] S_PIN   = 4'd4;
	localparam logic [S_W-1:0] S_VIC   = 4'd5;
	localparam logic [S_W-1:0] S_TAKE  = 4'd6;
	localparam logic [S_W-1:0] S_WB    = 4'd7;
	localparam logic [S_W-1:0] S_FETCH = 4'd8;
	localparam logic [S_W-1:0] S_INST  = 4'd9;
	localparam logic [S_W-1:0] S_REL   = 4'd10;
	localparam logic [S_W-1:0] S_DISP2 = 4'd11;
	localparam logic [S_W-1:0] S_DISP3 = 4'd12;
	localparam logic [S_W-1:0] S_SCAN  = 4'd13;
	localparam logic [S_W-1:0] S_FIN   = 4'd14;

	logic [S_W-1:0]    state_q, state_n;
	logic [STAT_W-1:0] fin_stat_q, fin_stat_n;
	logic              fin_frame_q, fin_frame_n;

	// State and pending final status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fin_stat_q  <= ST_OK;
			fin_frame_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			fin_stat_q  <= fin_stat_n;
			fin_frame_q <= fin_frame_n;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// Next state and command for the datapath.
	always_comb begin
		state_n     = state_q;
		fin_stat_n  = fin_stat_q;
		fin_frame_n = fin_frame_q;
		cmd         = '0;
		cmd.op      = OP_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LATCH;
					state_n = S_MATCH;
				end
			end
			S_MATCH: begin
				cmd.op  = OP_MATCH;
				state_n = S_ENC;
			end
			S_ENC: begin
				cmd.op  = OP_ENC;
				state_n = S_DEC;
			end
			S_DEC: begin
				fin_frame_n = 1'b0;
				fin_stat_n  = ST_OK;
				state_n     = S_FIN;
				case (st.mode)
					MODE_READ: begin
						if (st.file_zero) begin
							fin_stat_n = ST_BAD_FILE;
						end else if (st.hit) begin
							if (st.pin_zero) cmd.op = OP_REMOVE;
							state_n = S_PIN;
						end else begin
							state_n = S_VIC;
						end
					end
					MODE_ALLOC: begin
						if (st.file_zero) begin
							fin_stat_n = ST_BAD_FILE;
						end else if (st.hit) begin
							fin_stat_n  = ST_RESIDENT;
							fin_frame_n = 1'b1;
						end else begin
							state_n = S_VIC;
						end
					end
					MODE_UNPIN: begin
						if (!st.hit) begin
							fin_stat_n = ST_NOT_RES;
						end else if (st.pin_zero) begin
							fin_stat_n  = ST_NOT_PINNED;
							fin_frame_n = 1'b1;
						end else begin
							cmd.op  = OP_UNPIN;
							state_n = S_REL;
						end
					end
					MODE_DISPOSE: begin
						if (!st.hit) begin
							fin_stat_n = ST_NOT_RES;
						end else if (!st.pin_zero) begin
							fin_stat_n  = ST_PINNED;
							fin_frame_n = 1'b1;
						end else begin
							cmd.op  = OP_REMOVE;
							state_n = S_DISP2;
						end
					end
					MODE_FLUSH: begin
						if (st.file_zero) begin
							fin_stat_n = ST_BAD_FILE;
						end else begin
							cmd.op  = OP_SCAN_INIT;
							state_n = S_SCAN;
						end
					end
					default: begin
						fin_stat_n = ST_OK;
					end
				endcase
			end
			S_PIN: begin
				cmd.op      = OP_PIN_INC;
				fin_stat_n  = ST_OK;
				fin_frame_n = 1'b1;
				state_n     = S_FIN;
			end
			S_VIC: begin
				cmd.op  = OP_VICT;
				state_n = S_TAKE;
			end
			S_TAKE: begin
				if (st.victim_none) begin
					fin_stat_n  = ST_NO_FREE;
					fin_frame_n = 1'b0;
					state_n     = S_FIN;
				end else begin
					cmd.op  = OP_REMOVE;
					state_n = S_WB;
				end
			end
			S_WB: begin
				// A dirty victim's write-back word takes its tags in the same cycle that they are cleared.
				if (!st.victim_dirty || st.out_free) begin
					cmd.op = OP_CLEAR;
					if (st.victim_dirty) begin
						cmd.emit      = 1'b1;
						cmd.kind      = KIND_WBACK;
						cmd.use_frame = 1'b1;
						cmd.req_tag   = 1'b1;
					end
					state_n = (st.mode == MODE_READ) ? S_FETCH : S_INST;
				end
			end
			S_FETCH: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.kind      = KIND_FETCH;
					cmd.use_frame = 1'b1;
					state_n       = S_INST;
				end
			end
			S_INST: begin
				cmd.op      = OP_INSTALL;
				fin_stat_n  = ST_OK;
				fin_frame_n = 1'b1;
				state_n     = S_FIN;
			end
			S_REL: begin
				if (st.pin_zero) cmd.op = st.love ? OP_PUT_KEEP : OP_PUT_VICTIM;
				fin_stat_n  = ST_OK;
				fin_frame_n = 1'b1;
				state_n     = S_FIN;
			end
			S_DISP2: begin
				cmd.op  = OP_PUT_VICTIM;
				state_n = S_DISP3;
			end
			S_DISP3: begin
				if (st.out_free) begin
					cmd.op        = OP_CLEAR;
					cmd.emit      = 1'b1;
					cmd.kind      = KIND_DISP;
					cmd.use_frame = 1'b1;
					fin_stat_n    = ST_OK;
					fin_frame_n   = 1'b1;
					state_n       = S_FIN;
				end
			end
			S_SCAN: begin
				// One frame per cycle, lowest first; a dirty frame waits for the result register.
				if (st.scan_end) begin
					fin_stat_n  = ST_OK;
					fin_frame_n = 1'b0;
					state_n     = S_FIN;
				end else if (!st.cand) begin
					cmd.op = OP_NEXT;
				end else if (!st.pin_zero) begin
					fin_stat_n  = ST_PINNED;
					fin_frame_n = 1'b1;
					state_n     = S_FIN;
				end else if (!st.victim_dirty) begin
					cmd.op = OP_CLEAR_NEXT;
				end else if (st.out_free) begin
					cmd.op        = OP_CLEAR_NEXT;
					cmd.emit      = 1'b1;
					cmd.kind      = KIND_WBACK;
					cmd.use_frame = 1'b1;
					cmd.req_tag   = 1'b1;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.kind      = KIND_FINAL;
					cmd.status    = fin_stat_q;
					cmd.use_frame = fin_frame_q;
					cmd.last      = 1'b1;
					state_n       = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/bpfm_dp.sv
// ----------------------------------------------------------------------------
// Buffer pool frame manager datapath
// Frame tags, pin counts, replacement list and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfm_dp import bpfm_pkg::*; #(
	parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bpfm_in_if.sink   req,
	bpfm_out_if.source rsp,
	input  wire cmd_t cmd,
	output stat_t     st
);

	localparam int LW   = $clog2(NUM_FRAMES + 1);
	localparam int FW   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int HEAD = NUM_FRAMES;
	localparam logic [LW-1:0] HEAD_L = LW'(HEAD);

	// Per-frame state.
	logic [FILE_W-1:0] tag_file_q [NUM_FRAMES];
	logic [PAGE_W-1:0] tag_page_q [NUM_FRAMES];
	logic [PIN_W-1:0]  pin_q      [NUM_FRAMES];
	logic [NUM_FRAMES-1:0] dirty_q, valid_q;
	logic [LW-1:0] next_q  [NUM_FRAMES+1];
	logic [LW-1:0] prior_q [NUM_FRAMES+1];
	logic [LW-1:0] vp_q;

	// Request being worked on and working registers.
	logic [MODE_W-1:0] mode_q;
	logic [FILE_W-1:0] file_q;
	logic [PAGE_W-1:0] page_q;
	logic              dmark_q, love_q;
	logic [NUM_FRAMES-1:0] hit_vec_q, file_vec_q;
	logic              hit_q;
	logic [LW-1:0]     fidx_q;

	// Result word register.
	logic               out_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [STAT_W-1:0]  ostat_q;
	logic [FRAME_W-1:0] oframe_q;
	logic [FILE_W-1:0]  ofile_q;
	logic [PAGE_W-1:0]  opage_q;
	logic               olast_q;

	logic [FW-1:0] fi;
	logic [LW-1:0] enc_idx;
	logic [LW-1:0] p_rm, n_rm, p_keep, p_vic;

	assign fi = fidx_q[FW-1:0];

	// Lowest matching frame.
	always_comb begin
		enc_idx = '0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (hit_vec_q[i]) enc_idx = LW'(i);
		end
	end

	assign p_rm   = prior_q[fidx_q];
	assign n_rm   = next_q[fidx_q];
	assign p_keep = prior_q[HEAD];
	assign p_vic  = prior_q[vp_q];

	// Status towards the controller.
	always_comb begin
		st.mode         = mode_q;
		st.file_zero    = (file_q == '0);
		st.love         = love_q;
		st.hit          = hit_q;
		st.pin_zero     = (pin_q[fi] == '0);
		st.victim_none  = (vp_q >= HEAD_L);
		st.victim_dirty = valid_q[fi] && dirty_q[fi];
		st.scan_end     = (fidx_q >= HEAD_L);
		st.cand         = file_vec_q[fi];
		st.out_free     = !out_valid_q || rsp.ready;
	end

	// Request capture, tag match and frame index.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				mode_q  <= req.mode;
				file_q  <= req.file_id;
				page_q  <= req.page_no;
				dmark_q <= req.dirty_mark;
				love_q  <= req.love;
			end
			OP_MATCH: begin
				for (int i = 0; i < NUM_FRAMES; i++) begin
					hit_vec_q[i]  <= valid_q[i] && tag_file_q[i] == file_q
						&& tag_page_q[i] == page_q;
					file_vec_q[i] <= valid_q[i] && tag_file_q[i] == file_q;
				end
			end
			OP_ENC: begin
				fidx_q <= enc_idx;
				hit_q  <= |hit_vec_q;
			end
			OP_VICT:      fidx_q <= vp_q;
			OP_SCAN_INIT: fidx_q <= '0;
			OP_NEXT, OP_CLEAR_NEXT: fidx_q <= fidx_q + LW'(1);
			default: begin
			end
		endcase
	end

	// Tags of a frame carry no reset: they are only read when it is valid.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_INSTALL) begin
			tag_file_q[fi] <= file_q;
			tag_page_q[fi] <= page_q;
		end else if (cmd.op == OP_CLEAR || cmd.op == OP_CLEAR_NEXT) begin
			tag_file_q[fi] <= '0;
			tag_page_q[fi] <= '0;
		end
	end

	// Pin counts, flags, replacement list and victim pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FRAMES; i++) pin_q[i] <= '0;
			dirty_q <= '0;
			valid_q <= '0;
			for (int i = 0; i <= NUM_FRAMES; i++) begin
				next_q[i]  <= (i == HEAD) ? LW'(0) : LW'(i + 1);
				prior_q[i] <= (i == 0) ? HEAD_L : LW'(i - 1);
			end
			vp_q <= '0;
		end else begin
			case (cmd.op)
				OP_REMOVE: begin
					if (vp_q == fidx_q) vp_q <= n_rm;
					next_q[p_rm]  <= n_rm;
					prior_q[n_rm] <= p_rm;
				end
				OP_PUT_KEEP: begin
					next_q[fidx_q]  <= HEAD_L;
					prior_q[fidx_q] <= p_keep;
					next_q[p_keep]  <= fidx_q;
					prior_q[HEAD]   <= fidx_q;
					if (vp_q == HEAD_L) vp_q <= fidx_q;
				end
				OP_PUT_VICTIM: begin
					next_q[fidx_q]  <= vp_q;
					prior_q[fidx_q] <= p_vic;
					next_q[p_vic]   <= fidx_q;
					prior_q[vp_q]   <= fidx_q;
					vp_q            <= fidx_q;
				end
				OP_PIN_INC: begin
					if (pin_q[fi] != '1) pin_q[fi] <= pin_q[fi] + PIN_W'(1);
				end
				OP_UNPIN: begin
					if (dmark_q) dirty_q[fi] <= 1'b1;
					pin_q[fi] <= pin_q[fi] - PIN_W'(1);
				end
				OP_INSTALL: begin
					valid_q[fi] <= 1'b1;
					dirty_q[fi] <= 1'b0;
					pin_q[fi]   <= PIN_W'(1);
				end
				OP_CLEAR, OP_CLEAR_NEXT: begin
					valid_q[fi] <= 1'b0;
					dirty_q[fi] <= 1'b0;
					pin_q[fi]   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Result word handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q   <= cmd.kind;
			ostat_q  <= cmd.status;
			oframe_q <= cmd.use_frame ? FRAME_W'(fidx_q) : '0;
			olast_q  <= cmd.last;
			if (cmd.kind == KIND_FINAL) begin
				ofile_q <= '0;
				opage_q <= '0;
			end else if (cmd.req_tag) begin
				ofile_q <= tag_file_q[fi];
				opage_q <= tag_page_q[fi];
			end else begin
				ofile_q <= file_q;
				opage_q <= page_q;
			end
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.kind     = kind_q;
	assign rsp.status   = ostat_q;
	assign rsp.frame    = oframe_q;
	assign rsp.req_file = ofile_q;
	assign rsp.req_page = opage_q;
	assign rsp.last     = olast_q;

endmodule

`default_nettype wire

// File: rtl/buffer_pool_frame_manager.sv
// ----------------------------------------------------------------------------
// Buffer pool frame manager
// Page frame pool with tag match, pin counts and an ordered replacement list.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (read, unpin, allocate, dispose, flush) and
// are taken one at a time; req.ready is high only while the block is idle.
// Each request gives one or more words on rsp: write-back, fetch or dispose
// requests first, then one final status word with last set.
// A request passes through capture, tag match and encode; then a read
// hit pins its frame, a read miss or allocate takes a victim, writes it back
// if dirty and installs it (a read fetching first), an unpin or dispose
// updates the pin count and list, and a flush scans frames lowest first.
// The sequencing controller steps one datapath operation a cycle, holding
// while it waits for the result register.
// Reset clears all frames to invalid and unpinned and rebuilds the
// replacement list in frame order; no clearing pass is needed.
// When rsp stalls the controller holds in place until the result register
// frees; no word is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_pool_frame_manager import bpfm_pkg::*; #(
	parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bpfm_in_if.sink    req,
	bpfm_out_if.source rsp
);

	cmd_t  cmd;
	stat_t st;
	logic  in_ready;

	bpfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	bpfm_dp #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.st     (st)
	);

	assign req.ready = in_ready;

	// A word is only loaded when the result register is free.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("result word loaded over a waiting word");

	// A request is not followed by another in the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while busy");

	// The final word of a request carries the final kind.
	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |-> cmd.kind == KIND_FINAL)
		else $error("last word is not a final status");

endmodule

`default_nettype wire
